// ----- rtl/imu_tilt_angle_estimator_macros.svh -----
// Assertion macros for the tilt angle estimator.
// Included by the files that assert; expects clk and arst_n in scope.
`ifndef IMU_TILT_ANGLE_ESTIMATOR_MACROS_SVH
`define IMU_TILT_ANGLE_ESTIMATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define ITAE_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ITAE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/itae_pkg.sv -----
// Shared types and constants for the tilt angle estimator.
// No dependencies; used by itae_cfg and the top level.
`default_nettype none

package itae_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W = 10;
	localparam int OUT_TDW = 16;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_ALPHA    = 3'd0,
		REG_GYRO_LP_ALPHA  = 3'd1,
		REG_GYRO_HP_ALPHA  = 3'd2,
		REG_ACCEL_X_OFFSET = 3'd3,
		REG_ACCEL_Z_OFFSET = 3'd4,
		REG_GYRO_OFFSET    = 3'd5,
		REG_TIMESTEP_SCALE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        accel_alpha;
		logic [15:0]        gyro_lowpass_alpha;
		logic [15:0]        gyro_highpass_alpha;
		logic signed [9:0]  accel_x_offset;
		logic signed [9:0]  accel_z_offset;
		logic signed [9:0]  gyro_offset;
		logic [15:0]        timestep_scale;
	} cfg_t;

	localparam logic [15:0]       ACCEL_ALPHA_RST    = 16'd27853;
	localparam logic [15:0]       GYRO_LP_ALPHA_RST  = 16'd31130;
	localparam logic [15:0]       GYRO_HP_ALPHA_RST  = 16'd16384;
	localparam logic signed [9:0] ACCEL_X_OFFSET_RST = -10'sd136;
	localparam logic signed [9:0] ACCEL_Z_OFFSET_RST = 10'sd39;
	localparam logic signed [9:0] GYRO_OFFSET_RST    = -10'sd121;
	localparam logic [15:0]       TIMESTEP_SCALE_RST = 16'd655;

	// 57.30^2 scaled by 100: angle n fits when 100*n^2*(x^2+z^2) <= GAIN_SQ*x^2
	localparam logic [19:0] GAIN_SQ = 20'd328329;
	localparam logic [5:0]  ANGLE_MAX = 6'd57;

	typedef logic [19:0] ktab_t [64];

	function automatic ktab_t build_ktab();
		ktab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 20'(100 * i * i);
		end
		return t;
	endfunction

	// 100*n^2 for every search candidate
	localparam ktab_t K_TABLE = build_ktab();

endpackage

`default_nettype wire

// ----- rtl/imu_tilt_angle_estimator.sv -----
// Tilt angle estimator: sequencer and datapath around one shared multiplier.
// Depends on itae_pkg, itae_cfg, itae_mul and imu_tilt_angle_estimator_macros.svh.
//
//   channel   | dir | tdata (low bit up)                  | tuser
//   s_axis    | in  | accel_x, accel_z, gyro_y            | timestep_done
//   m_axis    | out | tilt_angle, zero pad to 16 bits     | -
//   cfg       | in  | cfg_index selects, cfg_data written | -
//
// An accepted beat yields one result beat; the angle search is skipped when both filtered
// accel values are zero. s_axis_tready stays low while a beat is in work and rises together
// with the result, so the next beat can be accepted in the same cycle as the result shows.
// Every product goes through the one registered multiplier: six low-pass products,
// the high-pass product, two squares, two halves of the gain product, the gyro term,
// then a 6-step binary search for the angle at two products and one compare per step.
// Reset clears the filter state and the output beat; a stalled m_axis holds the
// finished beat and the sequencer waits in its last step.
`default_nettype none
`include "imu_tilt_angle_estimator_macros.svh"

module imu_tilt_angle_estimator #(
	parameter int SAMPLE_WIDTH = itae_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [itae_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [itae_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// accel_x, accel_z, gyro_y from bit 0 up, zero pad to whole bytes
	input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
	// timestep_done
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tilt_angle in bits 9:0, zeros above
	output logic [itae_pkg::OUT_TDW-1:0]         m_axis_tdata
);
	import itae_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = SW + 2;
	localparam int BW = (SW + 1 > 20) ? SW + 1 : 20;
	localparam int PW = AW + BW;
	localparam int LW = SW + 18;
	localparam int GW = SW + 17;
	localparam int NW = SW + 18;
	localparam int CW = 2 * SW + 20;

	localparam logic signed [SW+3:0] SMAX = {5'b00000, {(SW-1){1'b1}}};
	localparam logic signed [SW+3:0] SMIN = {5'b11111, {(SW-1){1'b0}}};
	localparam logic signed [SW+1:0] AMAX = (SW+2)'(511);
	localparam logic signed [SW+1:0] AMIN = (SW+2)'(-512);

	typedef enum logic [17:0] {
		ST_IDLE    = 18'h00001,
		ST_LPX0    = 18'h00002,
		ST_LPX1    = 18'h00004,
		ST_LPX2    = 18'h00008,
		ST_LPZ1    = 18'h00010,
		ST_LPZ2    = 18'h00020,
		ST_LPG1    = 18'h00040,
		ST_LPG2    = 18'h00080,
		ST_HP      = 18'h00100,
		ST_SQZ     = 18'h00200,
		ST_SUM     = 18'h00400,
		ST_NLO     = 18'h00800,
		ST_NHI     = 18'h01000,
		ST_GT      = 18'h02000,
		ST_TRY_LO  = 18'h04000,
		ST_TRY_HI  = 18'h08000,
		ST_TRY_CMP = 18'h10000,
		ST_FINISH  = 18'h20000
	} state_t;

	state_t state_q;
	cfg_t   regs;

	logic signed [SW-1:0] rx_q, rz_q, rg_q;
	logic                 tick_q;
	logic signed [SW-1:0] xf_q, zf_q, gf_q, gprev_q, g_q;
	logic signed [LW-1:0] t_q;
	logic [2*SW-1:0]      sq_q, s_q;
	logic [CW-1:0]        n_q, lo_q;
	logic signed [GW-1:0] gt_q;
	logic [5:0]           m_q;
	logic [2:0]           bit_q;
	logic [OUT_W-1:0]     out_q;
	logic                 out_valid_q;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic [CW-1:0]        prod_u;

	logic signed [16:0]   oma_accel, oma_gyro;
	logic signed [SW:0]   abs_x, abs_z;
	logic [5:0]           cand;
	logic [19:0]          kval;

	logic signed [LW-1:0] t_add, lp_sum, lp_bias, lp_shr;
	logic signed [SW+3:0] lp_off, lp_res;
	logic signed [SW-1:0] lp_sat;

	logic [CW-1:0]        lhs;
	logic                 fits;

	logic                 accel_zero;
	logic signed [6:0]    m_signed;
	logic signed [NW-1:0] num, num_bias, num_shr;
	logic signed [SW+1:0] ang;
	logic [OUT_W-1:0]     ang_sat;
	logic                 out_free;
	logic                 s_beat;
	logic                 finish_go;

	itae_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	itae_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDW'(out_q);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_beat        = s_axis_tvalid && s_axis_tready;
	assign finish_go     = (state_q == ST_FINISH) && out_free;

	assign oma_accel = 17'sd32768 - $signed({1'b0, regs.accel_alpha});
	assign oma_gyro  = 17'sd32768 - $signed({1'b0, regs.gyro_lowpass_alpha});
	assign abs_x     = xf_q[SW-1] ? -(SW+1)'(xf_q) : (SW+1)'(xf_q);
	assign abs_z     = zf_q[SW-1] ? -(SW+1)'(zf_q) : (SW+1)'(zf_q);
	assign cand      = m_q | (6'd1 << bit_q);
	assign kval      = K_TABLE[cand];
	assign prod_u    = CW'(prod[PW-2:0]);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LPX0: begin mul_a = AW'(rx_q); mul_b = BW'(regs.accel_alpha); end
			ST_LPX1: begin mul_a = AW'(xf_q); mul_b = BW'(oma_accel); end
			ST_LPX2: begin mul_a = AW'(rz_q); mul_b = BW'(regs.accel_alpha); end
			ST_LPZ1: begin mul_a = AW'(zf_q); mul_b = BW'(oma_accel); end
			ST_LPZ2: begin mul_a = AW'(rg_q); mul_b = BW'(regs.gyro_lowpass_alpha); end
			ST_LPG1: begin mul_a = AW'(gf_q); mul_b = BW'(oma_gyro); end
			ST_LPG2: begin mul_a = AW'(abs_x); mul_b = BW'(abs_x); end
			ST_HP: begin
				mul_a = AW'(g_q) + AW'(rg_q) - AW'(gprev_q);
				mul_b = BW'(regs.gyro_highpass_alpha);
			end
			ST_SQZ:    begin mul_a = AW'(abs_z); mul_b = BW'(abs_z); end
			ST_SUM:    begin mul_a = AW'(sq_q[SW-1:0]); mul_b = BW'(GAIN_SQ); end
			ST_NLO:    begin mul_a = AW'(sq_q[2*SW-1:SW]); mul_b = BW'(GAIN_SQ); end
			ST_NHI:    begin mul_a = AW'(gf_q); mul_b = BW'(regs.timestep_scale); end
			ST_GT:     begin mul_a = AW'(s_q[SW-1:0]); mul_b = BW'(kval); end
			ST_TRY_LO: begin mul_a = AW'(s_q[SW-1:0]); mul_b = BW'(kval); end
			ST_TRY_HI: begin mul_a = AW'(s_q[2*SW-1:SW]); mul_b = BW'(kval); end
			default: ;
		endcase
	end

	// filter finish: sum, divide by 2^15 toward zero, add offset, saturate
	always_comb begin
		t_add   = (state_q == ST_SQZ) ? '0 : t_q;
		lp_sum  = t_add + $signed(prod[LW-1:0]);
		lp_bias = lp_sum + (lp_sum[LW-1] ? LW'(32767) : LW'(0));
		lp_shr  = lp_bias >>> 15;
		case (state_q)
			ST_LPX2: lp_off = (SW+4)'(regs.accel_x_offset);
			ST_LPZ2: lp_off = (SW+4)'(regs.accel_z_offset);
			ST_LPG2: lp_off = (SW+4)'(regs.gyro_offset);
			default: lp_off = '0;
		endcase
		lp_res = $signed(lp_shr[SW+3:0]) + lp_off;
		if (lp_res > SMAX) begin
			lp_sat = SMAX[SW-1:0];
		end else if (lp_res < SMIN) begin
			lp_sat = SMIN[SW-1:0];
		end else begin
			lp_sat = lp_res[SW-1:0];
		end
	end

	assign lhs  = lo_q + (prod_u << SW);
	assign fits = (cand <= ANGLE_MAX) && (lhs <= n_q);

	// angle: signed search result, plus gyro term on tick, toward zero, saturated
	always_comb begin
		accel_zero = (xf_q == '0) && (zf_q == '0);
		m_signed   = xf_q[SW-1] ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});
		num        = (NW'(m_signed) <<< 16) + NW'(gt_q);
		num_bias   = num + (num[NW-1] ? NW'(65535) : NW'(0));
		num_shr    = num_bias >>> 16;
		ang        = tick_q ? num_shr[SW+1:0] : (SW+2)'(m_signed);
		if (accel_zero) begin
			ang_sat = '0;
		end else if (ang > AMAX) begin
			ang_sat = AMAX[OUT_W-1:0];
		end else if (ang < AMIN) begin
			ang_sat = AMIN[OUT_W-1:0];
		end else begin
			ang_sat = ang[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			xf_q        <= '0;
			zf_q        <= '0;
			gf_q        <= '0;
			gprev_q     <= '0;
		end else begin
			// a new beat replaces the one taken in the same cycle
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					state_q <= ST_LPX0;
				end
				ST_LPX0: state_q <= ST_LPX1;
				ST_LPX1: state_q <= ST_LPX2;
				ST_LPX2: begin
					xf_q    <= lp_sat;
					state_q <= ST_LPZ1;
				end
				ST_LPZ1: state_q <= ST_LPZ2;
				ST_LPZ2: begin
					zf_q    <= lp_sat;
					state_q <= ST_LPG1;
				end
				ST_LPG1: state_q <= ST_LPG2;
				ST_LPG2: state_q <= ST_HP;
				ST_HP:   state_q <= ST_SQZ;
				ST_SQZ: begin
					gf_q    <= lp_sat;
					gprev_q <= rg_q;
					state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_NLO;
				ST_NLO: state_q <= ST_NHI;
				ST_NHI: state_q <= ST_GT;
				ST_GT:  state_q <= accel_zero ? ST_FINISH : ST_TRY_HI;
				ST_TRY_LO: state_q <= ST_TRY_HI;
				ST_TRY_HI: state_q <= ST_TRY_CMP;
				ST_TRY_CMP: state_q <= (bit_q == 3'd0) ? ST_FINISH : ST_TRY_LO;
				ST_FINISH: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) begin
				rx_q   <= s_axis_tdata[SW-1:0];
				rz_q   <= s_axis_tdata[2*SW-1:SW];
				rg_q   <= s_axis_tdata[3*SW-1:2*SW];
				tick_q <= s_axis_tuser;
				m_q    <= '0;
				bit_q  <= 3'd5;
			end
			ST_LPX1, ST_LPZ1, ST_LPG1: t_q <= $signed(prod[LW-1:0]);
			ST_LPG2: g_q <= lp_sat;
			ST_HP:   sq_q <= prod[2*SW-1:0];
			ST_SUM:  s_q <= sq_q + prod[2*SW-1:0];
			ST_NLO:  n_q <= prod_u;
			ST_NHI:  n_q <= n_q + (prod_u << SW);
			ST_GT:   gt_q <= $signed(prod[GW-1:0]);
			ST_TRY_HI: lo_q <= prod_u;
			ST_TRY_CMP: begin
				// keep the candidate bit when the angle still fits
				if (fits) begin
					m_q <= cand;
				end
				bit_q <= bit_q - 3'd1;
			end
			ST_FINISH: if (out_free) begin
				out_q <= ang_sat;
			end
			default: ;
		endcase
	end

	`ITAE_ASSERT_NEXT(a_accept_starts, s_beat, state_q == ST_LPX0, "beat not started")
	`ITAE_ASSERT_IMPL(a_search_bound, state_q == ST_FINISH, m_q <= ANGLE_MAX, "search past limit")
	`ITAE_ASSERT_NEXT(a_finish_emits, finish_go, m_axis_tvalid && s_axis_tready, "beat not shown")
	`ITAE_ASSERT_NEXT(a_zero_accel, finish_go && accel_zero, m_axis_tdata == '0, "angle not zero")

endmodule

`default_nettype wire

// ----- rtl/itae_cfg.sv -----
// Configuration register file of the tilt angle estimator.
// Depends on itae_pkg for the register map, reset values and cfg_t.
`default_nettype none

module itae_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [itae_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [itae_pkg::CFG_DATA_W-1:0]  cfg_data,
	output itae_pkg::cfg_t                   regs
);
	import itae_pkg::*;

	cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.accel_alpha         <= ACCEL_ALPHA_RST;
			regs_q.gyro_lowpass_alpha  <= GYRO_LP_ALPHA_RST;
			regs_q.gyro_highpass_alpha <= GYRO_HP_ALPHA_RST;
			regs_q.accel_x_offset      <= ACCEL_X_OFFSET_RST;
			regs_q.accel_z_offset      <= ACCEL_Z_OFFSET_RST;
			regs_q.gyro_offset         <= GYRO_OFFSET_RST;
			regs_q.timestep_scale      <= TIMESTEP_SCALE_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_ACCEL_ALPHA:    regs_q.accel_alpha         <= cfg_data[15:0];
				REG_GYRO_LP_ALPHA:  regs_q.gyro_lowpass_alpha  <= cfg_data[15:0];
				REG_GYRO_HP_ALPHA:  regs_q.gyro_highpass_alpha <= cfg_data[15:0];
				REG_ACCEL_X_OFFSET: regs_q.accel_x_offset      <= cfg_data[9:0];
				REG_ACCEL_Z_OFFSET: regs_q.accel_z_offset      <= cfg_data[9:0];
				REG_GYRO_OFFSET:    regs_q.gyro_offset         <= cfg_data[9:0];
				REG_TIMESTEP_SCALE: regs_q.timestep_scale      <= cfg_data[15:0];
				default: ; // drop writes beyond the map
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ----- rtl/itae_mul.sv -----
// Shared signed multiplier with a registered product.
// Stand-alone; instantiated once by the top level.
`default_nettype none

module itae_mul #(
	parameter int AW = 18,
	parameter int BW = 20
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] prod
);

	logic signed [AW+BW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire
